@@ src/assert_macros.svh @@
// Assertion macros for the checker file of the edit distance engine.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the reset is high.
`define ED_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("edit distance engine: assertion failed");

// Next-cycle implication, disabled while the reset is high.
`define ED_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("edit distance engine: assertion failed");

`endif

@@ src/ed_pkg.sv @@
// Shared constants, codes and control types of the edit distance engine.
// No dependencies; the files that use it refer to it by scoped names.
package ed_pkg;

   // Largest reference length the block stores.
   localparam int MAX_LEN = 64;
   localparam int IDX_W   = $clog2(MAX_LEN);
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int SYM_W   = 8;
   localparam int DATA_W  = 16;
   localparam logic [DATA_W-1:0] COUNT_MAX = {DATA_W{1'b1}};

   // Item modes carried on the request channel.
   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_QUERY  = 2'd1,
      MODE_FINISH = 2'd2
   } mode_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_EMIT
   } state_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic load_ref;
      logic start_query;
      logic scan_issue;
      logic fetch;
      logic emit;
   } cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic len_zero;
      logic count_sat;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

@@ src/ed_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on ed_pkg for the payload widths.
interface ed_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                mode;
   logic [ed_pkg::SYM_W-1:0]  symbol;

   modport source (output valid, output mode, output symbol, input ready);
   modport sink   (input valid, input mode, input symbol, output ready);
endinterface

interface ed_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ed_pkg::DATA_W-1:0] distance;
   logic                      overflow;

   modport source (output valid, output distance, output overflow, input ready);
   modport sink   (input valid, input distance, input overflow, output ready);
endinterface

@@ src/ed_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ed_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port; the read data holds when not read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/ed_datapath.sv @@
// Datapath of the edit distance engine: reference and column memories,
// counters, the one-position-per-cycle column update and the result register.
// Depends on ed_pkg and ed_ram.
module ed_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  ed_pkg::cmd_type           cmd,
   output ed_pkg::status_type        status,
   input  logic [ed_pkg::SYM_W-1:0]  symbol,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [ed_pkg::DATA_W-1:0] rsp_distance,
   output logic                      rsp_overflow
);

   localparam int IDX_W  = ed_pkg::IDX_W;
   localparam int LEN_W  = ed_pkg::LEN_W;
   localparam int DATA_W = ed_pkg::DATA_W;
   localparam int SYM_W  = ed_pkg::SYM_W;

   logic [LEN_W-1:0]         len_ff, len_in;
   logic [DATA_W-1:0]        count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic [ed_pkg::MAX_LEN-1:0] colvalid_ff, colvalid_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [IDX_W-1:0]         wpos_ff, wpos_in;
   logic                     scan_vld_ff, scan_vld_in;
   logic                     cv_ff, cv_in;
   logic [DATA_W-1:0]        rdef_ff, rdef_in;
   logic [DATA_W-1:0]        diag_ff, diag_in;
   logic [DATA_W-1:0]        left_ff, left_in;
   logic [SYM_W-1:0]         sym_ff, sym_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        dist_ff, dist_in;
   logic                     rovf_ff, rovf_in;

   logic                     len_full;
   logic                     load_ok;
   logic [IDX_W-1:0]         last_idx;
   logic [IDX_W-1:0]         col_raddr;
   logic                     col_re;
   logic [DATA_W-1:0]        col_rdata;
   logic [SYM_W-1:0]         ref_rdata;
   logic [DATA_W-1:0]        old_val;
   logic [DATA_W:0]          up_val;
   logic [DATA_W:0]          left_val;
   logic [DATA_W:0]          sub_val;
   logic [DATA_W:0]          best_val;

   // Reference symbols, written in load order.
   ed_ram #(.WIDTH(SYM_W), .DEPTH(ed_pkg::MAX_LEN)) u_ref_ram (
      .clock (clock),
      .we    (load_ok),
      .waddr (len_ff[IDX_W-1:0]),
      .wdata (symbol),
      .re    (cmd.scan_issue),
      .raddr (pos_ff),
      .rdata (ref_rdata)
   );

   // Column entries 1 to MAX_LEN at addresses 0 to MAX_LEN-1.
   ed_ram #(.WIDTH(DATA_W), .DEPTH(ed_pkg::MAX_LEN)) u_col_ram (
      .clock (clock),
      .we    (scan_vld_ff),
      .waddr (wpos_ff),
      .wdata (best_val[DATA_W-1:0]),
      .re    (col_re),
      .raddr (col_raddr),
      .rdata (col_rdata)
   );

   // Address selection and status toward the sequencer.
   always_comb begin
      len_full  = (len_ff == LEN_W'(ed_pkg::MAX_LEN));
      load_ok   = cmd.load_ref && (count_ff == '0) && !len_full;
      last_idx  = IDX_W'(len_ff - LEN_W'(1));
      col_re    = cmd.scan_issue || cmd.fetch;
      col_raddr = cmd.fetch ? last_idx : pos_ff;

      status.len_zero  = (len_ff == '0);
      status.count_sat = (count_ff == ed_pkg::COUNT_MAX);
      status.scan_last = (pos_ff == last_idx);
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // One cell of the column: minimum of the up, left and diagonal moves.
   // An entry never written since the last clear holds its own index.
   always_comb begin
      old_val  = cv_ff ? col_rdata : rdef_ff;
      up_val   = {1'b0, old_val} + (DATA_W + 1)'(1);
      left_val = {1'b0, left_ff} + (DATA_W + 1)'(1);
      sub_val  = {1'b0, diag_ff} + (DATA_W + 1)'(ref_rdata != sym_ff);
      best_val = up_val;
      if (left_val < best_val) begin
         best_val = left_val;
      end
      if (sub_val < best_val) begin
         best_val = sub_val;
      end
   end

   // Next values of the datapath registers.
   always_comb begin
      len_in       = len_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      colvalid_in  = colvalid_ff;
      pos_in       = pos_ff;
      wpos_in      = wpos_ff;
      scan_vld_in  = cmd.scan_issue;
      cv_in        = cv_ff;
      rdef_in      = rdef_ff;
      diag_in      = diag_ff;
      left_in      = left_ff;
      sym_in       = sym_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dist_in      = dist_ff;
      rovf_in      = rovf_ff;

      // Reference load; a symbol past the end is dropped and flagged.
      if (load_ok) begin
         len_in = len_ff + LEN_W'(1);
      end
      if (cmd.load_ref && (count_ff == '0) && len_full) begin
         ovf_in = 1'b1;
      end

      // Start of a query symbol: the column head becomes the new count.
      if (cmd.start_query) begin
         if (status.count_sat) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + DATA_W'(1);
            left_in  = count_ff + DATA_W'(1);
            diag_in  = count_ff;
            sym_in   = symbol;
            pos_in   = '0;
         end
      end

      // Column read issue, shared by the scan and the final fetch.
      if (col_re) begin
         cv_in   = colvalid_ff[col_raddr];
         rdef_in = DATA_W'(col_raddr) + DATA_W'(1);
      end
      if (cmd.scan_issue) begin
         wpos_in = pos_ff;
         pos_in  = pos_ff + IDX_W'(1);
      end

      // Column write-back of the position read in the previous cycle.
      if (scan_vld_ff) begin
         colvalid_in[wpos_ff] = 1'b1;
         left_in              = best_val[DATA_W-1:0];
         diag_in              = old_val;
      end

      // Result transfer into the output register, then clear for the next pair.
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         dist_in      = status.len_zero ? count_ff : old_val;
         rovf_in      = ovf_ff;
         len_in       = '0;
         count_in     = '0;
         ovf_in       = 1'b0;
         colvalid_in  = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         colvalid_ff  <= '0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         colvalid_ff  <= colvalid_in;
         scan_vld_ff  <= scan_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      wpos_ff <= wpos_in;
      cv_ff   <= cv_in;
      rdef_ff <= rdef_in;
      diag_ff <= diag_in;
      left_ff <= left_in;
      sym_ff  <= sym_in;
      dist_ff <= dist_in;
      rovf_ff <= rovf_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = dist_ff;
   assign rsp_overflow = rovf_ff;

endmodule

@@ src/ed_ctrl.sv @@
// Sequencer of the edit distance engine: decodes request modes and steps
// the datapath through the column scan and the result fetch.
// Depends on ed_pkg.
module ed_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_mode,
   output logic               req_ready,
   output ed_pkg::cmd_type    cmd,
   input  ed_pkg::status_type status
);

   ed_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ed_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ed_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_mode)
                  ed_pkg::MODE_LOAD: begin
                     cmd.load_ref = 1'b1;
                  end
                  ed_pkg::MODE_QUERY: begin
                     cmd.start_query = 1'b1;
                     if (!status.count_sat && !status.len_zero) begin
                        state_in = ed_pkg::ST_SCAN;
                     end
                  end
                  ed_pkg::MODE_FINISH: begin
                     state_in = ed_pkg::ST_FETCH;
                  end
                  default: begin
                     // The unused mode is dropped.
                  end
               endcase
            end
         end
         ed_pkg::ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = ed_pkg::ST_DRAIN;
            end
         end
         ed_pkg::ST_DRAIN: begin
            state_in = ed_pkg::ST_IDLE;
         end
         ed_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ed_pkg::ST_EMIT;
         end
         ed_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ed_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ed_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/edit_distance_engine.sv @@
// Edit distance engine: Levenshtein distance between a stored reference
// string and a query string that streams in one symbol per request.
// Request channel (req_ch): mode 0 loads a reference symbol, mode 1
// processes a query symbol, mode 2 requests the distance; mode 3 is dropped.
// Response channel (rsp_ch): one transfer of distance and overflow flag for
// each mode 2 request. Both channels transfer when valid and ready are high.
// Sequencing: a load leaves the block idle. A query symbol passes through the
// scan and drain states (with an empty reference the block stays idle); the
// column memory has one read port and the scan updates one reference position
// per cycle. A finish request passes the fetch and emit states; emit loads its
// result into the output register once that register is free, and the block
// takes requests again in the same cycle that the result is offered.
// The output register decouples the sides: while a result waits for the
// receiver, loads and queries of the next pair proceed; a further finish
// request holds in the sequencer until the output register is free.
// Reset is synchronous and leaves an empty reference, an empty query, a
// cleared overflow flag and no pending result; there is no clearing pass.
// Depends on ed_pkg, ed_if, ed_ram, ed_datapath and ed_ctrl.
module edit_distance_engine (
   input  logic     clock,
   input  logic     reset,
   ed_req_if.sink   req_ch,
   ed_rsp_if.source rsp_ch
);

   ed_pkg::cmd_type    cmd;
   ed_pkg::status_type status;

   ed_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   ed_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .symbol       (req_ch.symbol),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_distance (rsp_ch.distance),
      .rsp_overflow (rsp_ch.overflow)
   );

endmodule

@@ src/ed_checker.sv @@
// Port-level checks of the edit distance engine, bound to the top level.
// Depends on ed_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ed_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [1:0]                req_mode,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [ed_pkg::DATA_W-1:0] rsp_distance,
   input logic                      rsp_overflow
);

   logic                    finish_xfer;
   logic                    rsp_stall;
   logic [ed_pkg::DATA_W:0] rsp_payload;

   assign finish_xfer = req_valid && req_ready && (req_mode == ed_pkg::MODE_FINISH);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_distance, rsp_overflow};

   // Reset leaves no pending result.
   `ED_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // A stalled result keeps its payload.
   `ED_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // A finish request blocks new requests while the result is fetched.
   `ED_ASSERT_NEXT(a_finish_busy, clock, reset, finish_xfer, !req_ready ##1 !req_ready)

   // A fresh result appears only after a finish request.
   `ED_ASSERT_IMPLY(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(finish_xfer, 3))

endmodule

bind edit_distance_engine ed_checker u_ed_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_mode     (req_ch.mode),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_distance (rsp_ch.distance),
   .rsp_overflow (rsp_ch.overflow)
);

@@ verif/testbench.sv @@
// Self-checking testbench for the edit distance engine: directed pairs, then random pairs.
// Depends on ed_pkg, on the ed_req_if and ed_rsp_if interfaces of the RTL and on edit_distance_engine.
// Every distance result is checked against a predictor of the block's own behavior or, for typed rows, the table.
module testbench;

   // The request mode that the block drops.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS = 217;

   typedef struct packed {
      logic [ed_pkg::DATA_W-1:0] distance;
      logic                      overflow;
   } result_type;

   typedef struct packed {
      logic [1:0]                mode;
      logic [ed_pkg::SYM_W-1:0]  symbol;
      logic                      typed;
      logic [ed_pkg::DATA_W-1:0] distance;
      logic                      overflow;
   } stimulus_type;

   logic clock = 1'b0;
   logic reset;

   ed_req_if req_ch ();
   ed_rsp_if rsp_ch ();

   edit_distance_engine i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Predictor state: the stored reference, the single table column, the counts and the overflow flag.
   logic [ed_pkg::SYM_W-1:0]  ref_symbols [ed_pkg::MAX_LEN];
   logic [ed_pkg::DATA_W-1:0] column [ed_pkg::MAX_LEN+1];
   int                        ref_count;
   int                        query_count;
   logic                      overflow_seen;

   result_type pending_distances [$];
   result_type head_result;
   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;
   int results_checked;
   int counted_requests;

   // Directed table. Rows with typed set carry a result that is known by inspection.
   stimulus_type directed_rows [22] = '{
      '{ed_pkg::MODE_FINISH, 8'h00, 1'b1, 16'd0, 1'b0},   // finish straight after reset
      '{ed_pkg::MODE_LOAD,   8'h00, 1'b0, 16'd0, 1'b0},
      '{ed_pkg::MODE_LOAD,   8'hFF, 1'b0, 16'd0, 1'b0},
      '{ed_pkg::MODE_FINISH, 8'hFF, 1'b1, 16'd2, 1'b0},   // empty query
      '{ed_pkg::MODE_QUERY,  8'hFF, 1'b0, 16'd0, 1'b0},
      '{ed_pkg::MODE_QUERY,  8'h00, 1'b0, 16'd0, 1'b0},
      '{ed_pkg::MODE_QUERY,  8'h80, 1'b0, 16'd0, 1'b0},
      '{ed_pkg::MODE_FINISH, 8'h00, 1'b1, 16'd3, 1'b0},   // empty reference
      '{ed_pkg::MODE_LOAD,   8'h5A, 1'b0, 16'd0, 1'b0},
      '{ed_pkg::MODE_QUERY,  8'h5A, 1'b0, 16'd0, 1'b0},
      '{ed_pkg::MODE_FINISH, 8'h00, 1'b1, 16'd0, 1'b0},   // exact match
      '{ed_pkg::MODE_LOAD,   8'h12, 1'b0, 16'd0, 1'b0},
      '{ed_pkg::MODE_QUERY,  8'h34, 1'b0, 16'd0, 1'b0},
      '{ed_pkg::MODE_FINISH, 8'h00, 1'b1, 16'd1, 1'b0},   // one substitution
      '{ed_pkg::MODE_LOAD,   8'h41, 1'b0, 16'd0, 1'b0},
      '{MODE_UNUSED,         8'hFF, 1'b0, 16'd0, 1'b0},   // dropped selector
      '{ed_pkg::MODE_QUERY,  8'h41, 1'b0, 16'd0, 1'b0},
      '{ed_pkg::MODE_LOAD,   8'h42, 1'b0, 16'd0, 1'b0},   // load after the query began
      '{ed_pkg::MODE_QUERY,  8'h43, 1'b0, 16'd0, 1'b0},
      '{ed_pkg::MODE_FINISH, 8'h00, 1'b0, 16'd0, 1'b0},
      '{MODE_UNUSED,         8'h00, 1'b0, 16'd0, 1'b0},
      '{ed_pkg::MODE_FINISH, 8'h7F, 1'b1, 16'd0, 1'b0}    // empty pair
   };

   // Returns the predictor to an empty reference and an empty query.
   function automatic void clear_pair();
      for (int i = 0; i < ed_pkg::MAX_LEN; i++) ref_symbols[i] = '0;
      for (int i = 0; i <= ed_pkg::MAX_LEN; i++) column[i] = ed_pkg::DATA_W'(i);
      ref_count = 0;
      query_count = 0;
      overflow_seen = 1'b0;
   endfunction

   // Advances the predictor by one request; returns 1 when the request yields a distance.
   function automatic bit edit_step(input logic [1:0] mode,
                                    input logic [ed_pkg::SYM_W-1:0] symbol,
                                    output result_type res);
      int diag;
      int old_cost;
      int best;
      int left_cost;
      int sub_cost;
      res = '0;
      case (mode)
         ed_pkg::MODE_LOAD: begin
            // Loads are ignored once the query has started.
            if (query_count == 0) begin
               if (ref_count >= ed_pkg::MAX_LEN) begin
                  overflow_seen = 1'b1;
               end else begin
                  ref_symbols[ref_count] = symbol;
                  ref_count++;
               end
            end
            return 1'b0;
         end
         ed_pkg::MODE_QUERY: begin
            if (query_count >= ed_pkg::COUNT_MAX) begin
               overflow_seen = 1'b1;
            end else begin
               // Recompute the column for one more query symbol.
               query_count++;
               diag = query_count - 1;
               column[0] = ed_pkg::DATA_W'(query_count);
               for (int y = 1; y <= ref_count; y++) begin
                  old_cost = column[y];
                  best = old_cost + 1;
                  left_cost = column[y-1] + 1;
                  sub_cost = diag + ((ref_symbols[y-1] == symbol) ? 0 : 1);
                  if (left_cost < best) best = left_cost;
                  if (sub_cost < best) best = sub_cost;
                  column[y] = ed_pkg::DATA_W'(best);
                  diag = old_cost;
               end
            end
            return 1'b0;
         end
         ed_pkg::MODE_FINISH: begin
            res.distance = column[ref_count];
            res.overflow = overflow_seen;
            clear_pair();
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Symbols come mostly from a small alphabet so that matches are common.
   function automatic logic [ed_pkg::SYM_W-1:0] pick_symbol();
      if ($urandom_range(99) < 70) return ed_pkg::SYM_W'(8'h61 + $urandom_range(3));
      return ed_pkg::SYM_W'($urandom_range(255));
   endfunction

   // Offers one request, waits for its transfer and records what it should produce.
   task automatic send_request(input logic [1:0] mode, input logic [ed_pkg::SYM_W-1:0] symbol,
                               input logic typed, input result_type typed_res);
      result_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.symbol <= symbol;
      do @(posedge clock); while (!req_ch.ready);
      if (mode != MODE_UNUSED && !(mode == ed_pkg::MODE_LOAD && query_count != 0))
         counted_requests++;
      if (edit_step(mode, symbol, predicted)) begin
         if (typed) predicted = typed_res;
         pending_distances = {pending_distances, predicted};
      end
   endtask

   task automatic send(input logic [1:0] mode, input logic [ed_pkg::SYM_W-1:0] symbol);
      send_request(mode, symbol, 1'b0, '0);
   endtask

   // One reference and query pair with occasional noise and a rare missing finish.
   task automatic run_pair(input int ref_len, input int query_len);
      for (int i = 0; i < ref_len; i++) begin
         send(ed_pkg::MODE_LOAD, pick_symbol());
         if ($urandom_range(99) < 4) send(MODE_UNUSED, ed_pkg::SYM_W'($urandom_range(255)));
      end
      for (int i = 0; i < query_len; i++) begin
         send(ed_pkg::MODE_QUERY, pick_symbol());
         if ($urandom_range(99) < 4) send(ed_pkg::MODE_LOAD, pick_symbol());
         if ($urandom_range(99) < 3) send(MODE_UNUSED, ed_pkg::SYM_W'($urandom_range(255)));
      end
      if ($urandom_range(99) < 95)
         send(ed_pkg::MODE_FINISH, ed_pkg::SYM_W'($urandom_range(255)));
   endtask

   task automatic run_random(input int target);
      int pick;
      int ref_len;
      int query_len;
      while (counted_requests < target) begin
         pick = $urandom_range(99);
         if (pick < 80) ref_len = $urandom_range(6);
         else if (pick < 92) ref_len = $urandom_range(24, 7);
         else ref_len = $urandom_range(ed_pkg::MAX_LEN + 6, ed_pkg::MAX_LEN - 4);
         query_len = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(30, 9);
         run_pair(ref_len, query_len);
      end
   endtask

   // Receiver: checks each result transfer and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_distances.size() == 0) begin
               $display("%0t: result with none expected: distance %0d overflow %0b",
                        $time, rsp_ch.distance, rsp_ch.overflow);
               mismatch_count++;
            end else begin
               head_result = pending_distances.pop_front();
               results_checked++;
               if (rsp_ch.distance !== head_result.distance) begin
                  $display("%0t: distance mismatch: expected %0d, actual %0d",
                           $time, head_result.distance, rsp_ch.distance);
                  mismatch_count++;
               end
               if (rsp_ch.overflow !== head_result.overflow) begin
                  $display("%0t: overflow mismatch: expected %0b, actual %0b",
                           $time, head_result.overflow, rsp_ch.overflow);
                  mismatch_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Main sequence: reset, directed table, then three stall profiles.
   initial begin
      mismatch_count = 0;
      results_checked = 0;
      counted_requests = 0;
      send_idle_pct = 21;
      recv_idle_pct = 63;
      clear_pair();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.mode <= ed_pkg::MODE_LOAD;
      req_ch.symbol <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].mode, directed_rows[i].symbol, directed_rows[i].typed,
                      '{directed_rows[i].distance, directed_rows[i].overflow});

      // Full reference with extra symbols past the end, then a full one alone.
      run_pair(ed_pkg::MAX_LEN + 2, 4);
      run_pair(ed_pkg::MAX_LEN, 0);
      run_random(PHASE_ITEMS);

      send_idle_pct = 63;
      recv_idle_pct = 21;
      run_random(2 * PHASE_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(3 * PHASE_ITEMS);
      req_ch.valid <= 1'b0;

      while (pending_distances.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d counted requests under three stall profiles, including a full",
               counted_requests);
      $display("reference with dropped extra symbols; %0d distances checked.",
               results_checked);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
